/* rtl/core/svpwm_pkg.sv */
package svpwm_pkg;

  localparam int ANGLE_W   = 16;
  localparam int SPEED_W   = 17;
  localparam int PULSE_W   = 25;
  localparam int CMD_W     = 2;
  localparam int REG_IDX_W = 2;

  // Q(16-F).F angle format
  localparam int ANGLE_FRAC_BITS = 8;

  localparam logic [ANGLE_W-1:0] CENTER_ANGLE_Q  = ANGLE_W'(23040);
  localparam logic [SPEED_W-1:0] DEFAULT_SPEED_Q = SPEED_W'(6554);
  localparam logic [SPEED_W-1:0] SPEED_MIN_Q     = SPEED_W'(655);
  localparam logic [SPEED_W-1:0] SPEED_MAX_Q     = SPEED_W'(65536);

  localparam logic [ANGLE_W-1:0] ONE_DEGREE_Q = ANGLE_W'(1 << ANGLE_FRAC_BITS);

  // 180 degrees = 45 << (F + 2): power-of-two part is a shift, 45 is a reciprocal multiply
  localparam int                 SWING_W      = 24;
  localparam logic [SWING_W-1:0] FULL_SWING_Q = SWING_W'(180 << ANGLE_FRAC_BITS);
  localparam int                 SWING_SHIFT  = ANGLE_FRAC_BITS + 2;
  localparam int                 SWING_ODD    = 45;

  // floor(n / 45) for n < 2^31: (n * M) >> 36, then one correction step
  localparam int                 QMAG_W       = 31;
  localparam int                 QUOT_W       = 26;
  localparam int                 RECIP_SHIFT  = 36;
  localparam logic [QMAG_W-1:0]  RECIP_MUL    = QMAG_W'((64'd1 << RECIP_SHIFT) / SWING_ODD);

  localparam logic [PULSE_W-1:0] MIN_PULSE_RST  = PULSE_W'(1000000);
  localparam logic [PULSE_W-1:0] MAX_PULSE_RST  = PULSE_W'(2000000);
  localparam logic [ANGLE_W-1:0] LOW_ANGLE_RST  = ANGLE_W'(0);
  localparam logic [ANGLE_W-1:0] HIGH_ANGLE_RST = ANGLE_W'(46080);

  typedef enum logic [CMD_W-1:0] {
    CMD_SET    = 2'd0,
    CMD_SMOOTH = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_code_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MIN_PULSE  = 2'd0,
    REG_MAX_PULSE  = 2'd1,
    REG_LOW_ANGLE  = 2'd2,
    REG_HIGH_ANGLE = 2'd3
  } reg_idx_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;    // update servo state from the input beat
    logic mul_en;    // angle * span stage
    logic recip_en;  // reciprocal multiply stage
    logic load_out;  // correction, pulse add, output register load
  } svpwm_cmd_t;

endpackage

/* rtl/core/servo_smooth_position_pwm_core.sv */
// A beat is accepted in the idle state; its result passes the MUL, RECIP and FIX states
//   (angle*span multiply, reciprocal multiply, correction) into the output register.
//   No new beat is taken until the last result has been loaded there.
// An untaken result stalls the next beat in its last stage; input stays closed meanwhile.
// Reset (synchronous, active high): servo at center angle, goal at center, default
//   speed, not moving; pulse range 1 ms..2 ms, angle limits 0..180 degrees.
module servo_smooth_position_pwm_core #(
  parameter logic [svpwm_pkg::ANGLE_W-1:0] CENTER_ANGLE  = svpwm_pkg::CENTER_ANGLE_Q,
  parameter logic [svpwm_pkg::SPEED_W-1:0] DEFAULT_SPEED = svpwm_pkg::DEFAULT_SPEED_Q
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration write port
  input  logic                                   cfg_we,
  input  logic        [svpwm_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic        [svpwm_pkg::PULSE_W-1:0]   cfg_wdata,
  // input beat
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic        [svpwm_pkg::CMD_W-1:0]     command,
  input  logic signed [svpwm_pkg::ANGLE_W:0]     angle_in,
  input  logic        [svpwm_pkg::SPEED_W-1:0]   speed_in,
  // result beat
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic        [svpwm_pkg::ANGLE_W-1:0]   servo_angle,
  output logic        [svpwm_pkg::ANGLE_W-1:0]   target_angle,
  output logic                                   moving,
  output logic        [svpwm_pkg::PULSE_W-1:0]   pulse_ns,
  output logic                                   pulse_written
);
  import svpwm_pkg::*;

  // Control path: a four-state sequencer. The accept cycle updates the servo
  // state (clamps, smooth start, easing step); the MUL, RECIP and FIX states
  // after it compute the pulse width for the new position.
  svpwm_cmd_t cmd;

  svpwm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Datapath: config registers, servo state, pulse pipeline and the output
  // register. Input payload is read straight off the ports during the
  // accept cycle; it is stable there by the handshake rules.
  svpwm_dp #(
    .CENTER_ANGLE  (CENTER_ANGLE),
    .DEFAULT_SPEED (DEFAULT_SPEED)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .command       (command),
    .angle_in      (angle_in),
    .speed_in      (speed_in),
    .servo_angle   (servo_angle),
    .target_angle  (target_angle),
    .moving        (moving),
    .pulse_ns      (pulse_ns),
    .pulse_written (pulse_written)
  );

endmodule

/* rtl/core/svpwm_ctrl.sv */
module svpwm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output svpwm_pkg::svpwm_cmd_t cmd
);
  import svpwm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_RECIP,
    S_FIX
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.accept   = (state == S_IDLE) && in_valid;
    cmd.mul_en   = (state == S_MUL);
    cmd.recip_en = (state == S_RECIP);
    cmd.load_out = (state == S_FIX) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_RECIP;
        end
        S_RECIP: begin
          state <= S_FIX;
        end
        S_FIX: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_MUL))
    else $error("accepted beat did not start the pulse pipeline");

  a_recip_to_fix: assert property (@(posedge clk) disable iff (rst)
    (state == S_RECIP) |=> (state == S_FIX))
    else $error("reciprocal stage did not advance");

  a_fix_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIX && !out_valid) |=> (out_valid && state == S_IDLE))
    else $error("finished result not loaded into free output register");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !cmd.accept)
    else $error("state update while pipeline busy");
`endif

endmodule

/* rtl/core/svpwm_dp.sv */
module svpwm_dp #(
  parameter logic [svpwm_pkg::ANGLE_W-1:0] CENTER_ANGLE  = svpwm_pkg::CENTER_ANGLE_Q,
  parameter logic [svpwm_pkg::SPEED_W-1:0] DEFAULT_SPEED = svpwm_pkg::DEFAULT_SPEED_Q
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  svpwm_pkg::svpwm_cmd_t                    cmd,
  input  logic                                     cfg_we,
  input  logic        [svpwm_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic        [svpwm_pkg::PULSE_W-1:0]     cfg_wdata,
  input  logic        [svpwm_pkg::CMD_W-1:0]       command,
  input  logic signed [svpwm_pkg::ANGLE_W:0]       angle_in,
  input  logic        [svpwm_pkg::SPEED_W-1:0]     speed_in,
  output logic        [svpwm_pkg::ANGLE_W-1:0]     servo_angle,
  output logic        [svpwm_pkg::ANGLE_W-1:0]     target_angle,
  output logic                                     moving,
  output logic        [svpwm_pkg::PULSE_W-1:0]     pulse_ns,
  output logic                                     pulse_written
);
  import svpwm_pkg::*;

  localparam int PROD_W = ANGLE_W + 1 + PULSE_W + 1;

  // configuration
  logic [PULSE_W-1:0] min_pulse;
  logic [PULSE_W-1:0] max_pulse;
  logic [ANGLE_W-1:0] low_angle;
  logic [ANGLE_W-1:0] high_angle;

  // servo state
  logic [ANGLE_W-1:0] position;
  logic [ANGLE_W-1:0] goal;
  logic [SPEED_W-1:0] step_fraction;
  logic               in_motion;
  logic               written;

  logic [ANGLE_W-1:0] position_next;
  logic [ANGLE_W-1:0] goal_next;
  logic [SPEED_W-1:0] step_fraction_next;
  logic               in_motion_next;
  logic               written_next;

  // clamps
  logic signed [ANGLE_W+1:0] ang_ext;
  logic signed [ANGLE_W+1:0] ang_lo;
  logic signed [ANGLE_W+1:0] ang_cl;
  logic signed [ANGLE_W+1:0] low_ext;
  logic signed [ANGLE_W+1:0] high_ext;
  logic [ANGLE_W-1:0]        ang_clamped;
  logic [SPEED_W-1:0]        spd_clamped;

  // smooth gap and tick step
  logic signed [ANGLE_W:0]   sgap;
  logic signed [ANGLE_W:0]   smag;
  logic signed [ANGLE_W:0]   tdiff;
  logic [ANGLE_W-1:0]        tmag;
  logic [ANGLE_W+SPEED_W-1:0] step_prod;
  logic [ANGLE_W-1:0]        step;

  // pulse pipeline
  logic [SWING_W-1:0]        pos_ext;
  logic [SWING_W-1:0]        a_ext;
  logic [ANGLE_W-1:0]        a_lim;
  logic signed [PULSE_W:0]   span;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  prod_sh;
  logic signed [QMAG_W:0]    n_val;
  logic [QMAG_W-1:0]         qmag;
  logic                      qneg;
  logic [2*QMAG_W-1:0]       recip_prod;
  logic [QUOT_W-1:0]         q0;
  logic [QMAG_W:0]           rem;
  logic [QUOT_W-1:0]         q_fix;
  logic signed [QUOT_W:0]    q_signed;
  logic signed [PULSE_W+1:0] pulse_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_pulse  <= MIN_PULSE_RST;
      max_pulse  <= MAX_PULSE_RST;
      low_angle  <= LOW_ANGLE_RST;
      high_angle <= HIGH_ANGLE_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_MIN_PULSE:  min_pulse  <= cfg_wdata;
        REG_MAX_PULSE:  max_pulse  <= cfg_wdata;
        REG_LOW_ANGLE:  low_angle  <= cfg_wdata[ANGLE_W-1:0];
        REG_HIGH_ANGLE: high_angle <= cfg_wdata[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  // raise to low limit first, then lower to high limit (crossed limits give high)
  always_comb begin
    ang_ext     = {angle_in[ANGLE_W], angle_in};
    low_ext     = $signed({2'b00, low_angle});
    high_ext    = $signed({2'b00, high_angle});
    ang_lo      = (ang_ext < low_ext) ? low_ext : ang_ext;
    ang_cl      = (ang_lo > high_ext) ? high_ext : ang_lo;
    ang_clamped = ang_cl[ANGLE_W-1:0];
    if (speed_in < SPEED_MIN_Q) begin
      spd_clamped = SPEED_MIN_Q;
    end else if (speed_in > SPEED_MAX_Q) begin
      spd_clamped = SPEED_MAX_Q;
    end else begin
      spd_clamped = speed_in;
    end
  end

  always_comb begin
    sgap      = $signed({1'b0, ang_clamped}) - $signed({1'b0, position});
    smag      = sgap[ANGLE_W] ? -sgap : sgap;
    tdiff     = $signed({1'b0, goal}) - $signed({1'b0, position});
    tmag      = tdiff[ANGLE_W] ? ANGLE_W'(-tdiff) : tdiff[ANGLE_W-1:0];
    step_prod = tmag * step_fraction;
    // step <= tmag, so the upper bit of the shifted product is always zero
    step      = step_prod[16 +: ANGLE_W];
  end

  always_comb begin
    position_next      = position;
    goal_next          = goal;
    step_fraction_next = step_fraction;
    in_motion_next     = in_motion;
    written_next       = 1'b0;
    case (cmd_code_t'(command))
      CMD_SET: begin
        position_next  = ang_clamped;
        goal_next      = ang_clamped;
        in_motion_next = 1'b0;
        written_next   = 1'b1;
      end
      CMD_SMOOTH: begin
        goal_next          = ang_clamped;
        step_fraction_next = spd_clamped;
        in_motion_next     = (smag > $signed({1'b0, ONE_DEGREE_Q}));
      end
      CMD_TICK: begin
        if (in_motion) begin
          written_next = 1'b1;
          if (tmag <= ONE_DEGREE_Q) begin
            position_next  = goal;
            in_motion_next = 1'b0;
          end else if (tdiff[ANGLE_W]) begin
            position_next = position - step;
          end else begin
            position_next = position + step;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= CENTER_ANGLE;
      goal          <= CENTER_ANGLE;
      step_fraction <= DEFAULT_SPEED;
      in_motion     <= 1'b0;
    end else if (cmd.accept) begin
      position      <= position_next;
      goal          <= goal_next;
      step_fraction <= step_fraction_next;
      in_motion     <= in_motion_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      written <= written_next;
    end
  end

  // stage 1: angle (limited to 180 deg) * signed span, divided by 2^(F+2)
  always_comb begin
    pos_ext = SWING_W'(position);
    a_ext   = (pos_ext > FULL_SWING_Q) ? FULL_SWING_Q : pos_ext;
    a_lim   = a_ext[ANGLE_W-1:0];
    span    = $signed({1'b0, max_pulse}) - $signed({1'b0, min_pulse});
    prod    = $signed({1'b0, a_lim}) * span;
    prod_sh = prod >>> SWING_SHIFT;
    n_val   = prod_sh[QMAG_W:0];
  end

  // floor for negatives: floor(n/45) = ~floor(~n/45)
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      qneg <= n_val[QMAG_W];
      qmag <= n_val[QMAG_W] ? ~n_val[QMAG_W-1:0] : n_val[QMAG_W-1:0];
    end
  end

  // stage 2: reciprocal multiply, estimate low by at most one
  assign recip_prod = qmag * RECIP_MUL;

  always_ff @(posedge clk) begin
    if (cmd.recip_en) begin
      q0 <= recip_prod[RECIP_SHIFT +: QUOT_W];
    end
  end

  // stage 3: correction and offset by the zero-degree width
  always_comb begin
    rem       = {1'b0, qmag} - ((QMAG_W + 1)'(q0) * (QMAG_W + 1)'(SWING_ODD));
    q_fix     = (rem >= (QMAG_W + 1)'(SWING_ODD)) ? q0 + QUOT_W'(1) : q0;
    q_signed  = qneg ? ~$signed({1'b0, q_fix}) : $signed({1'b0, q_fix});
    pulse_sum = $signed({2'b00, min_pulse}) + (PULSE_W + 2)'(q_signed);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      servo_angle   <= position;
      target_angle  <= goal;
      moving        <= in_motion;
      pulse_ns      <= pulse_sum[PULSE_W-1:0];
      pulse_written <= written;
    end
  end

endmodule

/* tb/sv/servo_smooth_position_pwm_core_tb.sv */
`timescale 1ns / 1ps

module servo_smooth_position_pwm_core_tb;
  import svpwm_pkg::*;

  // command code 3 has no enum member; the block must treat it as a no-op
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // kinds of rows in the directed plan
  localparam logic ROW_BEAT = 1'b0;
  localparam logic ROW_REG  = 1'b1;

  // where a row's expected result comes from
  localparam logic CHK_MODEL = 1'b0;
  localparam logic CHK_TABLE = 1'b1;

  localparam int PHASES         = 8;
  localparam int PHASE_BEATS    = 250;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 8;
  localparam int MAX_REPORTS    = 10;

  localparam longint PULSE_TOP = 20000000;
  localparam longint ANGLE_TOP = 46080;

  typedef struct packed {
    logic [ANGLE_W-1:0] cur;
    logic [ANGLE_W-1:0] tgt;
    logic               mv;
    logic [PULSE_W-1:0] pulse;
    logic               pw;
  } servo_result_t;

  typedef struct {
    logic                  kind;
    logic [REG_IDX_W-1:0]  idx;
    logic [PULSE_W-1:0]    wdata;
    logic [CMD_W-1:0]      cmd;
    logic signed [ANGLE_W:0] angle;
    logic [SPEED_W-1:0]    speed;
    logic                  from_table;
    servo_result_t         want;
  } plan_row_t;

  // ---------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [REG_IDX_W-1:0]   cfg_index = '0;
  logic [PULSE_W-1:0]     cfg_wdata = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [CMD_W-1:0]       command = '0;
  logic signed [ANGLE_W:0] angle_in = '0;
  logic [SPEED_W-1:0]     speed_in = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [ANGLE_W-1:0]     servo_angle;
  logic [ANGLE_W-1:0]     target_angle;
  logic                   moving;
  logic [PULSE_W-1:0]     pulse_ns;
  logic                   pulse_written;

  servo_smooth_position_pwm_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .angle_in     (angle_in),
    .speed_in     (speed_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .servo_angle  (servo_angle),
    .target_angle (target_angle),
    .moving       (moving),
    .pulse_ns     (pulse_ns),
    .pulse_written(pulse_written)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Servo predictor: own copy of registers and motion state
  // ---------------------------------------------------------------------------
  logic [PULSE_W-1:0] pw_lo;     // ns at 0 deg
  logic [PULSE_W-1:0] pw_hi;     // ns at 180 deg
  logic [ANGLE_W-1:0] ang_lo;
  logic [ANGLE_W-1:0] ang_hi;
  logic [ANGLE_W-1:0] pos_q;
  logic [ANGLE_W-1:0] goal_q;
  logic [SPEED_W-1:0] frac_q;
  logic               motion_q;

  servo_result_t pending_results[$];
  int            mismatches = 0;
  int            idle_cycles = 0;
  int            stall_left = 0;
  logic          no_gaps = 1'b0;   // set for stretches with no idling on either side

  // low clamp first, then high clamp: crossed limits end at ang_hi
  function automatic logic [ANGLE_W-1:0] limit_angle(logic signed [ANGLE_W:0] raw);
    longint a;
    a = raw;
    if (a < longint'(ang_lo)) a = ang_lo;
    if (a > longint'(ang_hi)) a = ang_hi;
    return a[ANGLE_W-1:0];
  endfunction

  function automatic logic [SPEED_W-1:0] limit_speed(logic [SPEED_W-1:0] raw);
    if (raw < SPEED_MIN_Q) return SPEED_MIN_Q;
    if (raw > SPEED_MAX_Q) return SPEED_MAX_Q;
    return raw;
  endfunction

  // linear map 0..180 deg -> pw_lo..pw_hi, floor division, never below zero
  function automatic logic [PULSE_W-1:0] pulse_for(logic [ANGLE_W-1:0] angle);
    longint a, span, prod, q, total;
    a = angle;
    if (a > longint'(FULL_SWING_Q)) a = FULL_SWING_Q;
    span  = longint'(pw_hi) - longint'(pw_lo);
    prod  = a * span;
    q     = prod / longint'(FULL_SWING_Q);
    if (prod < 0 && q * longint'(FULL_SWING_Q) != prod) q = q - 1;
    total = longint'(pw_lo) + q;
    if (total < 0) total = 0;
    return total[PULSE_W-1:0];
  endfunction

  function automatic servo_result_t advance_servo(logic [CMD_W-1:0] cmd,
                                                  logic signed [ANGLE_W:0] ang,
                                                  logic [SPEED_W-1:0] spd);
    servo_result_t r;
    logic          wr;
    longint        diff, mag, step;
    wr = 1'b0;
    if (cmd == CMD_SET) begin
      pos_q    = limit_angle(ang);
      goal_q   = pos_q;
      motion_q = 1'b0;
      wr       = 1'b1;
    end else if (cmd == CMD_SMOOTH) begin
      goal_q   = limit_angle(ang);
      frac_q   = limit_speed(spd);
      diff     = longint'(goal_q) - longint'(pos_q);
      mag      = (diff < 0) ? -diff : diff;
      motion_q = (mag > longint'(ONE_DEGREE_Q));
    end else if (cmd == CMD_TICK && motion_q) begin
      diff = longint'(goal_q) - longint'(pos_q);
      mag  = (diff < 0) ? -diff : diff;
      if (mag <= longint'(ONE_DEGREE_Q)) begin
        // close enough: snap and stop
        pos_q    = goal_q;
        motion_q = 1'b0;
      end else begin
        step = (mag * longint'(frac_q)) >> 16;
        if (diff < 0) step = -step;
        pos_q = 16'(longint'(pos_q) + step);
      end
      wr = 1'b1;
    end
    r.cur   = pos_q;
    r.tgt   = goal_q;
    r.mv    = motion_q;
    r.pulse = pulse_for(pos_q);
    r.pw    = wr;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------
  // mostly short gaps, a few long ones
  function automatic int rand_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [ANGLE_W:0] rand_angle();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return 17'($urandom_range(0, 131071));      // any pattern, negatives too
    if (r < 4) return 17'($urandom_range(0, 512));         // near the low end
    if (r < 5) return 17'($urandom_range(45568, 46080));   // near the high end
    return 17'($urandom_range(0, 46080));
  endfunction

  function automatic logic [SPEED_W-1:0] rand_speed();
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return 17'($urandom_range(0, 131071));
    if (r == 1) return 17'($urandom_range(0, 2000));
    return 17'($urandom_range(655, 65536));
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus tasks; all called at a rising edge
  // ---------------------------------------------------------------------------
  // Present one input beat; valid stays up with a fixed payload until accepted.
  // A back-to-back beat keeps in_valid high, so it is never dropped and
  // re-raised within one time step.
  task automatic drive_beat(input logic [CMD_W-1:0] cmd,
                            input logic signed [ANGLE_W:0] ang,
                            input logic [SPEED_W-1:0] spd,
                            input logic from_table,
                            input servo_result_t want);
    int            gap;
    servo_result_t pred;
    gap = rand_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    angle_in <= ang;
    speed_in <= spd;
    do @(posedge clk); while (!in_ready);
    // accepted at this edge: state moves on here
    pred = advance_servo(cmd, ang, spd);
    pending_results.push_back(from_table ? want : pred);
  endtask

  // drop valid and wait for every outstanding result; block is idle after this
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // cfg_we is left high so back-to-back writes need no re-raise; caller lowers it
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PULSE_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_MIN_PULSE:  pw_lo  = val;
      REG_MAX_PULSE:  pw_hi  = val;
      REG_LOW_ANGLE:  ang_lo = val[ANGLE_W-1:0];
      REG_HIGH_ANGLE: ang_hi = val[ANGLE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input longint lo_ns, input longint hi_ns,
                            input longint lo_ang, input longint hi_ang);
    write_reg(REG_MIN_PULSE,  25'(lo_ns));
    write_reg(REG_MAX_PULSE,  25'(hi_ns));
    write_reg(REG_LOW_ANGLE,  25'(lo_ang));
    write_reg(REG_HIGH_ANGLE, 25'(hi_ang));
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Directed plan. Typed results: reset state, range extremes, the no-op code, a smooth
  // set and the inverted range at 180 deg. Everything else comes from the predictor.
  // ---------------------------------------------------------------------------
  plan_row_t dir_plan [26] = '{
    // tick while idle right after reset: center, 1.5 ms, no write
    '{ROW_BEAT, REG_MIN_PULSE, '0, CMD_TICK, 17'sd0, 17'd0, CHK_TABLE,
      '{16'd23040, 16'd23040, 1'b0, 25'd1500000, 1'b0}},
    '{ROW_BEAT, REG_MIN_PULSE, '0, CMD_SET, 17'sd0, 17'd0, CHK_TABLE,
      '{16'd0, 16'd0, 1'b0, 25'd1000000, 1'b1}},
    '{ROW_BEAT, REG_MIN_PULSE, '0, CMD_SET, 17'sd46080, 17'd0, CHK_TABLE,
      '{16'd46080, 16'd46080, 1'b0, 25'd2000000, 1'b1}},
    // most negative angle clamps to the low limit
    '{ROW_BEAT, REG_MIN_PULSE, '0, CMD_SET, 17'h10000, 17'd0, CHK_TABLE,
      '{16'd0, 16'd0, 1'b0, 25'd1000000, 1'b1}},
    '{ROW_BEAT, REG_MIN_PULSE, '0, CMD_SET, 17'h0FFFF, 17'h1FFFF, CHK_TABLE,
      '{16'd46080, 16'd46080, 1'b0, 25'd2000000, 1'b1}},
    // unused code: nothing moves, no write
    '{ROW_BEAT, REG_MIN_PULSE, '0, CMD_UNUSED, 17'h0AAAA, 17'h15555, CHK_TABLE,
      '{16'd46080, 16'd46080, 1'b0, 25'd2000000, 1'b0}},
    // smooth set never writes the pulse; zero speed saturates to the minimum
    '{ROW_BEAT, REG_MIN_PULSE, '0, CMD_SMOOTH, 17'sd0, 17'd0, CHK_TABLE,
      '{16'd46080, 16'd0, 1'b1, 25'd2000000, 1'b0}},
    '{ROW_BEAT, REG_MIN_PULSE, '0, CMD_TICK, 17'sd0, 17'd0, CHK_MODEL, '0},
    '{ROW_BEAT, REG_MIN_PULSE, '0, CMD_TICK, 17'sd0, 17'd0, CHK_MODEL, '0},
    // full speed: lands on the goal, then snaps and stops
    '{ROW_BEAT, REG_MIN_PULSE, '0, CMD_SMOOTH, 17'sd23040, 17'h1FFFF, CHK_MODEL, '0},
    '{ROW_BEAT, REG_MIN_PULSE, '0, CMD_TICK, 17'sd0, 17'd0, CHK_MODEL, '0},
    '{ROW_BEAT, REG_MIN_PULSE, '0, CMD_TICK, 17'sd0, 17'd0, CHK_MODEL, '0},
    // gap of exactly one degree: no motion
    '{ROW_BEAT, REG_MIN_PULSE, '0, CMD_SMOOTH, 17'sd23296, 17'd6554, CHK_MODEL, '0},
    '{ROW_BEAT, REG_MIN_PULSE, '0, CMD_TICK, 17'sd0, 17'd0, CHK_MODEL, '0},
    // just over one degree at the slowest speed: smallest step
    '{ROW_BEAT, REG_MIN_PULSE, '0, CMD_SMOOTH, 17'sd23297, 17'd655, CHK_MODEL, '0},
    '{ROW_BEAT, REG_MIN_PULSE, '0, CMD_TICK, 17'sd0, 17'd0, CHK_MODEL, '0},
    // negative goal, speed above 1.0
    '{ROW_BEAT, REG_MIN_PULSE, '0, CMD_SMOOTH, 17'h1FFFF, 17'd100000, CHK_MODEL, '0},
    '{ROW_BEAT, REG_MIN_PULSE, '0, CMD_TICK, 17'sd0, 17'd0, CHK_MODEL, '0},
    // inverted pulse range: falls with angle, floor rounding
    '{ROW_REG, REG_MIN_PULSE, 25'd20000000, CMD_SET, 17'sd0, 17'd0, CHK_MODEL, '0},
    '{ROW_REG, REG_MAX_PULSE, 25'd0, CMD_SET, 17'sd0, 17'd0, CHK_MODEL, '0},
    '{ROW_BEAT, REG_MIN_PULSE, '0, CMD_SET, 17'sd1, 17'd0, CHK_MODEL, '0},
    '{ROW_BEAT, REG_MIN_PULSE, '0, CMD_SET, 17'sd46080, 17'd0, CHK_TABLE,
      '{16'd46080, 16'd46080, 1'b0, 25'd0, 1'b1}},
    // crossed angle limits: everything ends at the high limit
    '{ROW_REG, REG_LOW_ANGLE, 25'd30000, CMD_SET, 17'sd0, 17'd0, CHK_MODEL, '0},
    '{ROW_REG, REG_HIGH_ANGLE, 25'd10000, CMD_SET, 17'sd0, 17'd0, CHK_MODEL, '0},
    '{ROW_BEAT, REG_MIN_PULSE, '0, CMD_SET, 17'sd0, 17'd0, CHK_MODEL, '0},
    '{ROW_BEAT, REG_MIN_PULSE, '0, CMD_SMOOTH, 17'sd40000, 17'd32768, CHK_MODEL, '0}
  };

  // ---------------------------------------------------------------------------
  // Result side: random out_ready stalls, in-order check against the queue
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    servo_result_t got, want;
    if (out_valid && out_ready) begin
      got = '{servo_angle, target_angle, moving, pulse_ns, pulse_written};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] unexpected result beat: cur=%0d tgt=%0d mv=%0b pulse=%0d pw=%0b",
                   $realtime, got.cur, got.tgt, got.mv, got.pulse, got.pw);
      end else begin
        want = pending_results.pop_front();
        if (got.cur !== want.cur || got.tgt !== want.tgt || got.mv !== want.mv ||
            got.pulse !== want.pulse || got.pw !== want.pw) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] result mismatch", $realtime);
            $display("  exp cur=%0d tgt=%0d mv=%0b pulse=%0d pw=%0b",
                     want.cur, want.tgt, want.mv, want.pulse, want.pw);
            $display("  got cur=%0d tgt=%0d mv=%0b pulse=%0d pw=%0b",
                     got.cur, got.tgt, got.mv, got.pulse, got.pw);
          end
        end
      end
    end
    // back-pressure: occasional stalls of random length, none in gap-free stretches
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!no_gaps && $urandom_range(0, 9) == 0) begin
      stall_left <= rand_gap();
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog: cycles in which no beat and no register write moves
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int                     sent, pick, n;
    longint                 lo_ns, hi_ns, lo_ang, hi_ang;

    // predictor matches the block's reset state
    pw_lo    = MIN_PULSE_RST;
    pw_hi    = MAX_PULSE_RST;
    ang_lo   = LOW_ANGLE_RST;
    ang_hi   = HIGH_ANGLE_RST;
    pos_q    = CENTER_ANGLE_Q;
    goal_q   = CENTER_ANGLE_Q;
    frac_q   = DEFAULT_SPEED_Q;
    motion_q = 1'b0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed plan; register rows wait until the block has gone idle
    foreach (dir_plan[i]) begin
      if (dir_plan[i].kind == ROW_REG) begin
        drain_results();
        write_reg(dir_plan[i].idx, dir_plan[i].wdata);
      end else begin
        cfg_we <= 1'b0;
        drive_beat(dir_plan[i].cmd, dir_plan[i].angle, dir_plan[i].speed,
                   dir_plan[i].from_table, dir_plan[i].want);
      end
    end

    // random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin lo_ns = MIN_PULSE_RST; hi_ns = MAX_PULSE_RST;
                 lo_ang = LOW_ANGLE_RST; hi_ang = HIGH_ANGLE_RST; end
        1: begin lo_ns = 0; hi_ns = PULSE_TOP; lo_ang = 0; hi_ang = ANGLE_TOP; end
        2: begin lo_ns = PULSE_TOP; hi_ns = 0; lo_ang = 0; hi_ang = ANGLE_TOP; end
        3: begin lo_ns = PULSE_TOP; hi_ns = PULSE_TOP; lo_ang = ANGLE_TOP; hi_ang = ANGLE_TOP; end
        4: begin  // crossed limits
          lo_ns  = $urandom_range(0, PULSE_TOP);
          hi_ns  = $urandom_range(0, PULSE_TOP);
          lo_ang = $urandom_range(23041, ANGLE_TOP);
          hi_ang = $urandom_range(0, 23040);
        end
        default: begin
          lo_ns  = $urandom_range(0, PULSE_TOP);
          hi_ns  = $urandom_range(0, PULSE_TOP);
          lo_ang = $urandom_range(0, 20000);
          hi_ang = $urandom_range(lo_ang, ANGLE_TOP);
        end
      endcase
      drain_results();
      set_config(lo_ns, hi_ns, lo_ang, hi_ang);

      sent = 0;
      while (sent < PHASE_BEATS) begin
        no_gaps = ($urandom_range(0, 4) == 0);
        pick    = $urandom_range(0, 99);
        if (pick < 60) begin
          // move sequence: smooth set followed by a run of ticks
          drive_beat(CMD_SMOOTH, rand_angle(), rand_speed(), CHK_MODEL, '0);
          sent++;
          n = $urandom_range(1, 48);
          repeat (n) begin
            drive_beat(CMD_TICK, 17'($urandom_range(0, 131071)),
                       17'($urandom_range(0, 131071)), CHK_MODEL, '0);
            sent++;
          end
        end else if (pick < 80) begin
          // jump, then a few ticks that must do nothing
          drive_beat(CMD_SET, rand_angle(), 17'($urandom_range(0, 131071)), CHK_MODEL, '0);
          sent++;
          n = $urandom_range(0, 3);
          repeat (n) begin
            drive_beat(CMD_TICK, rand_angle(), rand_speed(), CHK_MODEL, '0);
            sent++;
          end
        end else begin
          // noise: any code, any payload
          drive_beat(2'($urandom_range(0, 3)), 17'($urandom_range(0, 131071)),
                     17'($urandom_range(0, 131071)), CHK_MODEL, '0);
          sent++;
        end
      end
    end

    // wind down: all results in, then a wait for stray beats
    no_gaps = 1'b0;
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) mismatches++;

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
